// ===== rtl/cab_pkg.sv =====
// ----------------------------------------------------------------------------
// cab_pkg: shared types and constants of the collider axis bound block
// Shape classes, fixed-point widths and the item passed from front to back.
// ----------------------------------------------------------------------------
package cab_pkg;

    localparam int COORD_BITS    = 32;
    localparam int ROT_FRAC_BITS = 14;
    localparam int EXT_BITS      = 31;
    localparam int ROW_BITS      = 16;
    localparam int KIND_BITS     = 3;
    localparam int QUEUE_DEPTH   = 4;

    // Raw shape codes as they arrive on the input.
    localparam logic [KIND_BITS-1:0] KIND_BOX      = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_SPHERE   = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_CYLINDER = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_CAPSULE  = 3'd3;

    // Reach rule class after decoding.
    typedef logic [1:0] t_cls;
    localparam t_cls CLS_BOX    = 2'd0;
    localparam t_cls CLS_SPHERE = 2'd1;
    localparam t_cls CLS_CYL    = 2'd2;
    localparam t_cls CLS_CAPS   = 2'd3;

    typedef struct packed {
        t_cls                       cls;
        logic [EXT_BITS-1:0]        ext_x;
        logic [EXT_BITS-1:0]        ext_y;
        logic [EXT_BITS-1:0]        ext_z;
        logic signed [COORD_BITS-1:0] centre;
        logic [ROW_BITS-1:0]        mag_x;
        logic [ROW_BITS-1:0]        mag_y;
        logic [ROW_BITS-1:0]        mag_z;
    } t_item;

    // Handshake between a producer and the queue.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

endpackage

// ===== rtl/cab_front.sv =====
// ----------------------------------------------------------------------------
// cab_front: input stage
// Accepts a beat, decodes the shape class and forms the row magnitudes.
// ----------------------------------------------------------------------------
module cab_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [cab_pkg::KIND_BITS-1:0]        i_shape_kind,
    input  logic [cab_pkg::EXT_BITS-1:0]         i_ext_x,
    input  logic [cab_pkg::EXT_BITS-1:0]         i_ext_y,
    input  logic [cab_pkg::EXT_BITS-1:0]         i_ext_z,
    input  logic signed [cab_pkg::COORD_BITS-1:0] i_centre,
    input  logic signed [cab_pkg::ROW_BITS-1:0]  i_row_x,
    input  logic signed [cab_pkg::ROW_BITS-1:0]  i_row_y,
    input  logic signed [cab_pkg::ROW_BITS-1:0]  i_row_z,
    output cab_pkg::t_push                       o_push,
    input  logic                                 i_q_full
);

    logic            r_fv;
    cab_pkg::t_item  r_item;
    cab_pkg::t_item  n_item;
    logic            w_take;
    logic            w_push;

    function automatic logic [cab_pkg::ROW_BITS-1:0] row_mag(
        input logic signed [cab_pkg::ROW_BITS-1:0] v
    );
        return v[cab_pkg::ROW_BITS-1] ? cab_pkg::ROW_BITS'(-v) : v;
    endfunction

    assign w_push  = r_fv && !i_q_full;
    assign o_stall = r_fv && i_q_full;
    assign w_take  = i_valid && !o_stall;

    always_comb begin
        case (i_shape_kind)
            cab_pkg::KIND_SPHERE:   n_item.cls = cab_pkg::CLS_SPHERE;
            cab_pkg::KIND_CYLINDER: n_item.cls = cab_pkg::CLS_CYL;
            cab_pkg::KIND_CAPSULE:  n_item.cls = cab_pkg::CLS_CAPS;
            default:                n_item.cls = cab_pkg::CLS_BOX;
        endcase
        n_item.ext_x  = i_ext_x;
        n_item.ext_y  = i_ext_y;
        n_item.ext_z  = i_ext_z;
        n_item.centre = i_centre;
        n_item.mag_x  = row_mag(i_row_x);
        n_item.mag_y  = row_mag(i_row_y);
        n_item.mag_z  = row_mag(i_row_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_take) begin
            r_fv <= 1'b1;
        end else if (w_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

    assign o_push.valid = w_push;
    assign o_push.item  = r_item;

endmodule

// ===== rtl/cab_queue.sv =====
// ----------------------------------------------------------------------------
// cab_queue: decoupling queue
// A short FIFO of decoded items between the front and the back.
// ----------------------------------------------------------------------------
module cab_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cab_pkg::t_push  i_push,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nonempty,
    output cab_pkg::t_item  o_item
);

    localparam int PW = $clog2(cab_pkg::QUEUE_DEPTH);

    cab_pkg::t_item r_mem [cab_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [PW:0]    r_count;
    logic           w_pop;

    assign o_full     = (r_count == (PW+1)'(cab_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign w_pop      = i_pop && o_nonempty;
    assign o_item     = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push.valid && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push.valid && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.item;
        end
    end

endmodule

// ===== rtl/cab_back.sv =====
// ----------------------------------------------------------------------------
// cab_back: execution pipeline
// Square root of the cylinder term, products, rounding and saturation.
// ----------------------------------------------------------------------------
module cab_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_nonempty,
    input  cab_pkg::t_item                       i_item,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [cab_pkg::COORD_BITS-1:0] o_lower,
    output logic signed [cab_pkg::COORD_BITS-1:0] o_upper
);

    localparam int F     = cab_pkg::ROT_FRAC_BITS;
    localparam int RADW  = 2 * F;
    localparam int RW    = F + 3;
    localparam int PRODW = cab_pkg::EXT_BITS + cab_pkg::ROW_BITS;
    localparam int SUMW  = PRODW + 2;
    localparam int REACHW = SUMW - F + 1;
    localparam int WIDEW = REACHW + 2;
    localparam int NST   = F + 1;

    typedef struct packed {
        cab_pkg::t_item  item;
        logic            zero;
        logic [RADW-1:0] rad;
        logic [RW-1:0]   rem;
        logic [F-1:0]    root;
    } t_stage;

    logic                    w_adv;
    logic [NST-1:0]          r_v;
    t_stage                  r_st [NST];
    t_stage                  n_st [NST];
    logic [2*cab_pkg::ROW_BITS-1:0] w_sq;

    logic                    r_mv;
    logic [PRODW-1:0]        r_p0, r_p1, r_p2;
    logic                    r_madd;
    logic [cab_pkg::EXT_BITS-1:0] r_mex;
    logic signed [cab_pkg::COORD_BITS-1:0] r_mc;

    logic                    r_av;
    logic [REACHW-1:0]       r_reach;
    logic signed [cab_pkg::COORD_BITS-1:0] r_ac;

    logic                    r_ov;

    logic [F:0]              w_across;
    logic [cab_pkg::ROW_BITS-1:0] w_opx, w_opy, w_opz;
    logic [SUMW-1:0]         w_sum;
    logic [REACHW-1:0]       w_reach;
    logic signed [WIDEW-1:0] w_lo, w_hi;

    function automatic logic signed [cab_pkg::COORD_BITS-1:0] sat(
        input logic signed [WIDEW-1:0] v
    );
        logic signed [WIDEW-1:0] hi;
        logic signed [WIDEW-1:0] lo;
        hi = WIDEW'({1'b0, {(cab_pkg::COORD_BITS-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi) begin
            return hi[cab_pkg::COORD_BITS-1:0];
        end else if (v < lo) begin
            return lo[cab_pkg::COORD_BITS-1:0];
        end
        return v[cab_pkg::COORD_BITS-1:0];
    endfunction

    assign w_adv = !r_ov || !i_stall;
    assign o_pop = w_adv && i_q_nonempty;

    // Stage 0: square of the up entry and the radicand for ceil(sqrt(1 - a^2)).
    assign w_sq = i_item.mag_y * i_item.mag_y;
    always_comb begin
        n_st[0].item = i_item;
        n_st[0].zero = (w_sq >= (2*cab_pkg::ROW_BITS)'(1 << RADW));
        n_st[0].rad  = RADW'({RADW{1'b1}} - w_sq[RADW-1:0]);
        n_st[0].rem  = '0;
        n_st[0].root = '0;
    end

    // One result bit of the root per stage.
    for (genvar k = 1; k < NST; k++) begin : g_sqrt
        localparam int B = F - k;
        logic [RW-1:0] w_rsh;
        logic [RW-1:0] w_trial;
        assign w_rsh   = {r_st[k-1].rem[RW-3:0], r_st[k-1].rad[2*B+1 -: 2]};
        assign w_trial = {1'b0, r_st[k-1].root, 2'b01};
        always_comb begin
            n_st[k] = r_st[k-1];
            if (w_rsh >= w_trial) begin
                n_st[k].rem  = w_rsh - w_trial;
                n_st[k].root = {r_st[k-1].root[F-2:0], 1'b1};
            end else begin
                n_st[k].rem  = w_rsh;
                n_st[k].root = {r_st[k-1].root[F-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_mv <= 1'b0;
            r_av <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_v  <= {r_v[NST-2:0], i_q_nonempty};
            r_mv <= r_v[NST-1];
            r_av <= r_mv;
            r_ov <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < NST; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // Product stage: operands chosen by the shape class.
    always_comb begin
        w_across = r_st[NST-1].zero ? '0 : ({1'b0, r_st[NST-1].root} + 1'b1);
        case (r_st[NST-1].item.cls)
            cab_pkg::CLS_BOX: begin
                w_opx = r_st[NST-1].item.mag_x;
                w_opy = r_st[NST-1].item.mag_y;
                w_opz = r_st[NST-1].item.mag_z;
            end
            cab_pkg::CLS_CYL: begin
                w_opx = cab_pkg::ROW_BITS'(w_across);
                w_opy = r_st[NST-1].item.mag_y;
                w_opz = '0;
            end
            cab_pkg::CLS_CAPS: begin
                w_opx = '0;
                w_opy = r_st[NST-1].item.mag_y;
                w_opz = '0;
            end
            default: begin
                w_opx = '0;
                w_opy = '0;
                w_opz = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p0   <= PRODW'(r_st[NST-1].item.ext_x) * PRODW'(w_opx);
            r_p1   <= PRODW'(r_st[NST-1].item.ext_y) * PRODW'(w_opy);
            r_p2   <= PRODW'(r_st[NST-1].item.ext_z) * PRODW'(w_opz);
            r_madd <= (r_st[NST-1].item.cls == cab_pkg::CLS_SPHERE) ||
                      (r_st[NST-1].item.cls == cab_pkg::CLS_CAPS);
            r_mex  <= r_st[NST-1].item.ext_x;
            r_mc   <= r_st[NST-1].item.centre;
        end
    end

    // Sum and round up.
    assign w_sum   = SUMW'(r_p0) + SUMW'(r_p1) + SUMW'(r_p2) + SUMW'((1 << F) - 1);
    assign w_reach = REACHW'(w_sum >> F) + (r_madd ? REACHW'(r_mex) : '0);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_reach <= w_reach;
            r_ac    <= r_mc;
        end
    end

    assign w_lo = WIDEW'(r_ac) - $signed({2'b00, r_reach});
    assign w_hi = WIDEW'(r_ac) + $signed({2'b00, r_reach});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_lower <= sat(w_lo);
            o_upper <= sat(w_hi);
        end
    end

    assign o_valid = r_ov;

endmodule

// ===== rtl/collider_axis_bound.sv =====
// ----------------------------------------------------------------------------
// collider_axis_bound: world-axis bound of a posed collider
// One beat in gives the shape, extents, centre and one rotation row; one beat
// out gives the saturated lower and upper bound on that world axis.
// ----------------------------------------------------------------------------
// Usage: send three beats per collider, one per rotation row, for the X, Y
// and Z bounds. Both channels use valid and stall; a beat moves at a rising
// edge with valid high and stall low. Every input beat yields exactly one
// output beat, in order.
// Throughput is one beat per cycle while nothing stalls. The accepting edge
// loads the input register; the queue, the radicand stage, fourteen root
// stages (one root bit each, which sets the depth), the product stage, the
// sum stage and the output register then follow in that order.
// The back pipeline advances whenever the output register is empty or taken.
// When the receiver stalls, the back halts, the queue fills, and then the
// input register holds and raises o_stall. Reset (synchronous, active low)
// empties every stage and the queue; no beat is in flight afterwards.
// ----------------------------------------------------------------------------
module collider_axis_bound (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [cab_pkg::KIND_BITS-1:0]        i_shape_kind,
    input  logic [cab_pkg::EXT_BITS-1:0]         i_ext_x,
    input  logic [cab_pkg::EXT_BITS-1:0]         i_ext_y,
    input  logic [cab_pkg::EXT_BITS-1:0]         i_ext_z,
    input  logic signed [cab_pkg::COORD_BITS-1:0] i_centre,
    input  logic signed [cab_pkg::ROW_BITS-1:0]  i_row_x,
    input  logic signed [cab_pkg::ROW_BITS-1:0]  i_row_y,
    input  logic signed [cab_pkg::ROW_BITS-1:0]  i_row_z,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [cab_pkg::COORD_BITS-1:0] o_lower,
    output logic signed [cab_pkg::COORD_BITS-1:0] o_upper
);

    cab_pkg::t_push w_push;
    cab_pkg::t_item w_qitem;
    logic           w_qfull;
    logic           w_qnonempty;
    logic           w_pop;

    // Front: registers the beat and decodes the shape class.
    cab_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_shape_kind (i_shape_kind),
        .i_ext_x      (i_ext_x),
        .i_ext_y      (i_ext_y),
        .i_ext_z      (i_ext_z),
        .i_centre     (i_centre),
        .i_row_x      (i_row_x),
        .i_row_y      (i_row_y),
        .i_row_z      (i_row_z),
        .o_push       (w_push),
        .i_q_full     (w_qfull)
    );

    // Queue: lets the front keep taking beats while the back is held.
    cab_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_full     (w_qfull),
        .i_pop      (w_pop),
        .o_nonempty (w_qnonempty),
        .o_item     (w_qitem)
    );

    // Back: the arithmetic pipeline and the output register.
    cab_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (w_qnonempty),
        .i_item       (w_qitem),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_lower      (o_lower),
        .o_upper      (o_upper)
    );

endmodule
